### rtl/ers_pkg.sv
// ============================================================================
// ers_pkg - elevator request scheduler shared definitions
// Direction codes, request item layouts and stream widths.
// ============================================================================
`default_nettype none

package ers_pkg;

    // default floor count of the shaft
    localparam int FLOOR_COUNT_DEF = 4;

    // call button / lamp field width (floors 0..3, three kinds each)
    localparam int BUTTON_W = 12;

    // button kinds within one floor row
    localparam int KIND_HALL_UP   = 0;
    localparam int KIND_HALL_DOWN = 1;
    localparam int KIND_CAB       = 2;

    // travel direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // stream widths
    localparam int IN_W    = 18;
    localparam int OUT_W   = 20;
    localparam int TDATA_W = 24;

    // input request, declared high to low so bit 0 is call_buttons[0]
    typedef struct packed {
        logic                choose_dir;
        logic                serve_floor;
        logic                stop_pressed;
        logic [1:0]          sensed_floor;
        logic                floor_valid;
        logic [BUTTON_W-1:0] call_buttons;
    } in_item_t;

    // result, declared high to low so bit 0 is direction[0]
    typedef struct packed {
        logic                stop_lamp;
        logic                at_rest_safe;
        logic [1:0]          floor_indicator;
        logic [BUTTON_W-1:0] request_lamps;
        logic                requests_empty;
        logic                should_stop;
        logic [1:0]          direction;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/ers_update.sv
// ============================================================================
// ers_update - one scheduler tick
// Next request matrix, floor and direction plus the result fields.
// ============================================================================
`default_nettype none

module ers_update #(
    parameter int FLOOR_COUNT = ers_pkg::FLOOR_COUNT_DEF,
    localparam int RW = 3 * FLOOR_COUNT,
    localparam int FW = $clog2(FLOOR_COUNT)
) (
    input  var ers_pkg::in_item_t  in_item,
    input  wire logic [RW-1:0]     req_q,
    input  wire logic [FW-1:0]     floor_q,
    input  wire logic [1:0]        dir_q,
    output logic      [RW-1:0]     req_d,
    output logic      [FW-1:0]     floor_d,
    output logic      [1:0]        dir_d,
    output ers_pkg::out_item_t     result
);

    // button bits that map onto existing floors
    localparam int BW = (RW < ers_pkg::BUTTON_W) ? RW : ers_pkg::BUTTON_W;

    logic [RW-1:0] btn_ext;
    logic [RW-1:0] req_a;
    logic [FW-1:0] floor_a;
    logic [1:0]    dir_a;

    assign btn_ext = RW'(in_item.call_buttons[BW-1:0]);

    always_comb begin
        logic          above;
        logic          below;
        logic          any_req;
        logic [2:0]    row;
        logic [RW-1:0] req_b;
        logic [1:0]    dir_b;
        logic          stop_here;

        // stop clears requests and direction, otherwise latch buttons and take a valid sensed floor
        if (in_item.stop_pressed) begin
            req_a   = '0;
            floor_a = floor_q;
            dir_a   = ers_pkg::DIR_STOP;
        end else begin
            req_a = req_q | btn_ext;
            if (in_item.floor_valid && (int'(in_item.sensed_floor) < FLOOR_COUNT)) begin
                floor_a = FW'(in_item.sensed_floor);
            end else begin
                floor_a = floor_q;
            end
            dir_a = dir_q;
        end

        // serve: drop the current floor's row
        req_b = req_a;
        for (int i = 0; i < FLOOR_COUNT; i++) begin
            if (in_item.serve_floor && (FW'(i) == floor_a)) begin
                req_b[3*i +: 3] = 3'b000;
            end
        end

        above = 1'b0;
        below = 1'b0;
        row   = 3'b000;
        for (int i = 0; i < FLOOR_COUNT; i++) begin
            if (FW'(i) > floor_a) begin
                above = above | (|req_b[3*i +: 3]);
            end
            if (FW'(i) < floor_a) begin
                below = below | (|req_b[3*i +: 3]);
            end
            if (FW'(i) == floor_a) begin
                row = req_b[3*i +: 3];
            end
        end
        any_req = |req_b;

        // direction choice
        dir_b = dir_a;
        if (in_item.choose_dir) begin
            if (!any_req) begin
                dir_b = ers_pkg::DIR_STOP;
            end else if (dir_a == ers_pkg::DIR_UP) begin
                if (!above && below) begin
                    dir_b = ers_pkg::DIR_DOWN;
                end
            end else if (dir_a == ers_pkg::DIR_DOWN) begin
                if (!below && above) begin
                    dir_b = ers_pkg::DIR_UP;
                end
            end else if (below) begin
                dir_b = ers_pkg::DIR_DOWN;
            end else if (above) begin
                dir_b = ers_pkg::DIR_UP;
            end else begin
                dir_b = ers_pkg::DIR_STOP;
            end
        end

        if (row[ers_pkg::KIND_CAB]) begin
            stop_here = 1'b1;
        end else if (dir_b == ers_pkg::DIR_UP) begin
            stop_here = row[ers_pkg::KIND_HALL_UP] || !above;
        end else if (dir_b == ers_pkg::DIR_DOWN) begin
            stop_here = row[ers_pkg::KIND_HALL_DOWN] || !below;
        end else begin
            stop_here = 1'b0;
        end

        req_d   = req_b;
        floor_d = floor_a;
        dir_d   = dir_b;

        result.direction       = dir_b;
        result.should_stop     = stop_here;
        result.requests_empty  = !any_req;
        result.request_lamps   = ers_pkg::BUTTON_W'(req_b[BW-1:0]);
        result.floor_indicator = 2'(floor_a);
        result.at_rest_safe    = in_item.floor_valid && (dir_b == ers_pkg::DIR_STOP);
        result.stop_lamp       = in_item.stop_pressed;
    end

endmodule

`default_nettype wire

### rtl/elevator_request_scheduler.sv
// ============================================================================
// elevator_request_scheduler - collective control direction scheduler
// Latches call buttons into a floors x 3 request matrix, tracks the floor
// and travel direction, and reports stop decision and lamps every request.
// ============================================================================
//
//  channel | dir | ports                      | payload
//  --------+-----+----------------------------+---------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata  | buttons, sensor, stop/serve/choose
//  m_      | out | m_tvalid m_tready m_tdata  | direction, stop, lamps, floor
//
//  One request per cycle sustained while m_tready stays high. A request passes
//  the input register, then one pass of ers_update into the result register,
//  which also updates the request matrix, floor and direction state.
//  The input side keeps taking requests while a result waits on m_tready,
//  until both the input and result registers are full.
//  aresetn (synchronous, active low) empties both stages and resets the
//  state to no requests, floor zero, direction stop.
//
`default_nettype none

module elevator_request_scheduler #(
    parameter int FLOOR_COUNT = ers_pkg::FLOOR_COUNT_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [11:0] call_buttons, [12] floor_valid, [14:13] sensed_floor,
    // [15] stop_pressed, [16] serve_floor, [17] choose_dir, rest zero
    input  wire logic [ers_pkg::TDATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [1:0] direction, [2] should_stop, [3] requests_empty,
    // [15:4] request_lamps, [17:16] floor_indicator, [18] at_rest_safe,
    // [19] stop_lamp, rest zero
    output logic      [ers_pkg::TDATA_W-1:0] m_tdata
);

    localparam int RW      = 3 * FLOOR_COUNT;
    localparam int FW      = $clog2(FLOOR_COUNT);
    localparam int OUT_PAD = ers_pkg::TDATA_W - ers_pkg::OUT_W;

    // input stage
    logic               in_valid_reg, in_valid_next;
    ers_pkg::in_item_t  in_item_reg;

    // scheduler state
    logic [RW-1:0]      req_reg,   req_next;
    logic [FW-1:0]      floor_reg, floor_next;
    logic [1:0]         dir_reg,   dir_next;

    // result stage
    logic               out_valid_reg, out_valid_next;
    ers_pkg::out_item_t out_item_reg;
    ers_pkg::out_item_t result;

    logic s_accept;
    logic out_free;
    logic advance;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    ers_update #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_update (
        .in_item (in_item_reg),
        .req_q   (req_reg),
        .floor_q (floor_reg),
        .dir_q   (dir_reg),
        .req_d   (req_next),
        .floor_d (floor_next),
        .dir_d   (dir_next),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
            floor_reg     <= '0;
            dir_reg       <= ers_pkg::DIR_STOP;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                req_reg   <= req_next;
                floor_reg <= floor_next;
                dir_reg   <= dir_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= ers_pkg::in_item_t'(s_tdata[ers_pkg::IN_W-1:0]);
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_item_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an emergency stop leaves an empty matrix and direction stop
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.stop_pressed |=>
            (dir_reg == ers_pkg::DIR_STOP) && (req_reg == '0))
        else $error("stop request did not clear scheduler state");

    // a reported stop lamp always comes with an empty, stopped result
    a_stop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.stop_lamp |->
            out_item_reg.requests_empty && (out_item_reg.direction == ers_pkg::DIR_STOP))
        else $error("stop lamp result with pending requests or motion");

    // a held input request is neither dropped nor overwritten
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled input request lost");

    // state only moves when a request passes through the update stage
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(req_reg) && $stable(dir_reg) && $stable(floor_reg))
        else $error("scheduler state changed without a request");

endmodule

`default_nettype wire
